>>> src/mfsgd_pkg.sv
// Package: shared constants, types and fixed-point helpers for the MF SGD step.
`timescale 1ns / 1ps
package mfsgd_pkg;

  localparam int unsigned Users      = 65536;
  localparam int unsigned Items      = 16384;
  localparam int unsigned MaxFactors = 64;
  localparam int unsigned UserAw     = $clog2(Users);
  localparam int unsigned ItemAw     = $clog2(Items);
  localparam int unsigned FactAw     = $clog2(MaxFactors);
  localparam int unsigned CntW       = FactAw + 1;
  localparam logic [6:0]  BiasElem   = 7'd64;
  localparam logic [14:0] ScoreMin   = 15'd4096;
  localparam logic [14:0] ScoreMax   = 15'd20480;

  typedef enum logic [1:0] {
    CMD_TRAIN   = 2'd0,
    CMD_PREDICT = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MEAN  = 2'd0,
    REG_RATE  = 2'd1,
    REG_THETA = 2'd2,
    REG_NF    = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BRD,
    ST_DOT,
    ST_DOTEND,
    ST_SUM,
    ST_BUPD,
    ST_FRD,
    ST_FMUL,
    ST_FWR,
    ST_OUT
  } state_e;

  // SGD decay term: floor(theta*own/2^16)
  function automatic logic signed [17:0] sgd_decay(input logic signed [15:0] own,
                                                   input logic [15:0] theta);
    logic signed [33:0] rp;
    rp = 34'($signed({1'b0, theta})) * 34'(own);
    sgd_decay = 18'(rp >>> 16);
  endfunction

  // SGD step: sat(own + floor(lr*diff/2^16)), diff = grad - decay
  function automatic logic signed [15:0] sgd_apply(input logic signed [15:0] own,
                                                   input logic signed [33:0] diff,
                                                   input logic [15:0] lr);
    logic signed [50:0] prod;
    logic signed [35:0] d;
    logic signed [36:0] s;
    prod = 51'($signed({1'b0, lr})) * 51'(diff);
    d    = 36'(prod >>> 16);
    s    = 37'(d) + 37'(own);
    if (s > 37'sd32767) sgd_apply = 16'sh7fff;
    else if (s < -37'sd32768) sgd_apply = 16'sh8000;
    else sgd_apply = s[15:0];
  endfunction

endpackage

>>> src/mfsgd_ram.sv
// Generic single-port synchronous RAM, registered read.
`timescale 1ns / 1ps
module mfsgd_ram #(
  parameter int unsigned Aw = 8,
  parameter int unsigned Dw = 16
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] addr_i,
  input  logic [Dw-1:0] wdata_i,
  output logic [Dw-1:0] rdata_o
);
  logic [Dw-1:0] mem [2**Aw];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> src/matrix_factorization_sgd_step.sv
// Top level: biased matrix-factorization SGD step over memory-held tables.
`timescale 1ns / 1ps
// One word in, one word out. A train or predict word first runs the
// dot-product pass (one factor pair read per cycle from the two factor
// RAMs), then the bias sum; a train word then does the bias update and
// the factor update pass (read, multiply, write back per element). A load
// word writes at most one table entry. The result is held while out_stall_i
// is high, and the next word is taken once the block is idle again. The bias
// tables hold zero after reset through a clearing pass that sweeps all 65536
// user and 16384 item bias rows (one row of each per cycle),
// during which no word is accepted. Factor tables are not cleared.
module matrix_factorization_sgd_step import mfsgd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  cmd_i,
  input  logic [15:0] user_index_i,
  input  logic [13:0] item_index_i,
  input  logic [2:0]  rating_i,
  input  logic        load_table_i,
  input  logic [6:0]  elem_index_i,
  input  logic signed [15:0] load_value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [14:0] score_o,
  output logic signed [15:0] error_o
);

  // configuration
  logic [14:0] mean_q;
  logic [15:0] rate_q, theta_q;
  logic [6:0]  nf_reg_q;
  logic        cfg_we;
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= 15'd14748; rate_q <= 16'd328; theta_q <= 16'd1311; nf_reg_q <= 7'd32;
    end else if (cfg_we) begin
      case (reg_e'(paddr[3:2]))
        REG_MEAN:  mean_q   <= pwdata[14:0];
        REG_RATE:  rate_q   <= pwdata[15:0];
        REG_THETA: theta_q  <= pwdata[15:0];
        REG_NF:    nf_reg_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (reg_e'(paddr[3:2]))
      REG_MEAN:  prdata = {17'd0, mean_q};
      REG_RATE:  prdata = {16'd0, rate_q};
      REG_THETA: prdata = {16'd0, theta_q};
      REG_NF:    prdata = {25'd0, nf_reg_q};
      default:   prdata = '0;
    endcase
  end
  logic [CntW-1:0] nf;
  assign nf = (nf_reg_q > 7'(MaxFactors)) ? CntW'(MaxFactors) : CntW'(nf_reg_q);

  // captured word
  cmd_e            cmd_q;
  logic [UserAw-1:0] u_q;
  logic [ItemAw-1:0] i_q;
  logic [2:0]      rating_q;
  logic            tbl_q;
  logic [6:0]      elem_q;
  logic signed [15:0] lv_q;

  state_e st_q, st_d;
  logic [CntW-1:0] k_q, k_d;
  logic [UserAw:0] clr_q;
  logic clearing;
  assign clearing = ~clr_q[UserAw];

  // RAM ports
  logic ub_we, ib_we, uf_we, if_we;
  logic [UserAw-1:0] ub_a;
  logic [ItemAw-1:0] ib_a;
  logic [UserAw+FactAw-1:0] uf_a;
  logic [ItemAw+FactAw-1:0] if_a;
  logic [15:0] ub_wd, ib_wd, uf_wd, if_wd, ub_rd, ib_rd, uf_rd, if_rd;

  mfsgd_ram #(.Aw(UserAw), .Dw(16)) u_ubias (.clk_i, .we_i(ub_we), .addr_i(ub_a),
    .wdata_i(ub_wd), .rdata_o(ub_rd));
  mfsgd_ram #(.Aw(ItemAw), .Dw(16)) u_ibias (.clk_i, .we_i(ib_we), .addr_i(ib_a),
    .wdata_i(ib_wd), .rdata_o(ib_rd));
  mfsgd_ram #(.Aw(UserAw+FactAw), .Dw(16)) u_ufact (.clk_i, .we_i(uf_we), .addr_i(uf_a),
    .wdata_i(uf_wd), .rdata_o(uf_rd));
  mfsgd_ram #(.Aw(ItemAw+FactAw), .Dw(16)) u_ifact (.clk_i, .we_i(if_we), .addr_i(if_a),
    .wdata_i(if_wd), .rdata_o(if_rd));

  // datapath registers
  logic signed [31:0] prod_q;
  logic               prod_v_q;
  logic signed [39:0] acc_q;
  logic signed [15:0] bu_q, bi_q;
  logic signed [17:0] rbu_q, rbi_q;
  logic [14:0]        score_q;
  logic signed [15:0] err_q;
  logic signed [33:0] du_q, di_q;
  logic signed [15:0] pold_q, qold_q;
  logic signed [15:0] pnew, qnew;

  logic in_ok;
  assign in_ok = (cmd_q == CMD_TRAIN || cmd_q == CMD_PREDICT);

  logic accept_in;
  assign in_stall_o = (st_q != ST_IDLE) | clearing;
  assign accept_in  = in_valid_i & ~in_stall_o;
  assign out_valid_o = (st_q == ST_OUT);

  // raw prediction, clamp
  logic signed [27:0] dot;
  logic signed [29:0] raw;
  logic [14:0] score_c;
  assign dot = 28'(acc_q >>> 12);
  assign raw = 30'($signed({1'b0, mean_q})) + 30'(bu_q) + 30'(bi_q) + 30'(dot);
  assign score_c = (raw > 30'sd20480) ? ScoreMax :
                   (raw < 30'sd4096) ? ScoreMin : raw[14:0];

  always_comb begin
    st_d = st_q; k_d = k_q;
    ub_we = 1'b0; ib_we = 1'b0; uf_we = 1'b0; if_we = 1'b0;
    ub_a = u_q; ib_a = i_q;
    uf_a = {u_q, k_q[FactAw-1:0]}; if_a = {i_q, k_q[FactAw-1:0]};
    ub_wd = lv_q; ib_wd = lv_q; uf_wd = lv_q; if_wd = lv_q;
    if (clearing) begin
      ub_we = 1'b1; ib_we = 1'b1;
      ub_a = clr_q[UserAw-1:0]; ib_a = clr_q[ItemAw-1:0];
      ub_wd = '0; ib_wd = '0;
    end
    case (st_q)
      ST_IDLE: if (accept_in) begin
        st_d = ST_BRD; k_d = '0;
      end
      ST_BRD: begin
        if (cmd_q == CMD_LOAD) begin
          if (elem_q == BiasElem) begin
            ub_we = ~tbl_q; ib_we = tbl_q;
          end else if (elem_q < 7'(MaxFactors)) begin
            uf_a = {u_q, elem_q[FactAw-1:0]}; if_a = {i_q, elem_q[FactAw-1:0]};
            uf_we = ~tbl_q; if_we = tbl_q;
          end
          st_d = ST_OUT;
        end else if (!in_ok) st_d = ST_OUT;
        else begin
          st_d = ST_DOT; k_d = CntW'(1);
        end
      end
      ST_DOT: begin
        if (k_q >= nf) st_d = ST_DOTEND;
        else k_d = k_q + 1'b1;
      end
      ST_DOTEND: st_d = ST_SUM;
      ST_SUM: st_d = (cmd_q == CMD_TRAIN) ? ST_BUPD : ST_OUT;
      ST_BUPD: begin
        ub_we = 1'b1; ib_we = 1'b1;
        ub_wd = sgd_apply(bu_q, 34'(err_q) - 34'(rbu_q), rate_q);
        ib_wd = sgd_apply(bi_q, 34'(err_q) - 34'(rbi_q), rate_q);
        k_d = '0;
        st_d = (nf == '0) ? ST_OUT : ST_FRD;
      end
      ST_FRD: st_d = ST_FMUL;
      ST_FMUL: st_d = ST_FWR;
      ST_FWR: begin
        uf_we = 1'b1; if_we = 1'b1;
        uf_wd = pnew; if_wd = qnew;
        k_d = k_q + 1'b1;
        st_d = (k_q + 1'b1 >= nf) ? ST_OUT : ST_FRD;
      end
      ST_OUT: if (!out_stall_i) st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; k_q <= '0; clr_q <= '0; prod_v_q <= 1'b0;
    end else begin
      st_q <= st_d; k_q <= k_d;
      if (clearing) clr_q <= clr_q + 1'b1;
      prod_v_q <= (st_q == ST_DOT) && (k_q <= nf) && (nf != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      cmd_q <= cmd_e'(cmd_i); u_q <= user_index_i; i_q <= item_index_i;
      rating_q <= rating_i; tbl_q <= load_table_i; elem_q <= elem_index_i;
      lv_q <= load_value_i;
      acc_q <= '0; score_q <= '0; err_q <= '0;
    end
    if (st_q == ST_BRD) begin
      bu_q <= ub_rd; bi_q <= ib_rd;   // stale; rewritten below
    end
    // reads issued in ST_BRD land at ST_DOT (k=1); bias data arrives there too
    if (st_q == ST_DOT && k_q == CntW'(1)) begin
      bu_q <= ub_rd; bi_q <= ib_rd;
    end
    // bias decay terms ahead of the bias update
    if (st_q == ST_DOTEND) begin
      rbu_q <= sgd_decay(bu_q, theta_q);
      rbi_q <= sgd_decay(bi_q, theta_q);
    end
    prod_q <= $signed(uf_rd) * $signed(if_rd);
    if (prod_v_q) acc_q <= acc_q + 40'(prod_q);
    if (st_q == ST_SUM) begin
      score_q <= score_c;
      if (cmd_q == CMD_TRAIN)
        err_q <= 16'($signed({1'b0, rating_q, 12'd0}) - $signed({1'b0, score_c}));
    end
    // gradient minus decay per factor; item side uses the old user factor
    if (st_q == ST_FMUL) begin
      pold_q <= uf_rd; qold_q <= if_rd;
      du_q <= 34'((32'(err_q) * 32'($signed(if_rd))) >>> 12)
              - 34'(sgd_decay($signed(uf_rd), theta_q));
      di_q <= 34'((32'(err_q) * 32'($signed(uf_rd))) >>> 12)
              - 34'(sgd_decay($signed(if_rd), theta_q));
    end
  end

  assign pnew = sgd_apply(pold_q, du_q, rate_q);
  assign qnew = sgd_apply(qold_q, di_q, rate_q);

  assign score_o = score_q;
  assign error_o = err_q;

  property p_no_accept_busy;
    @(posedge clk_i) disable iff (!rst_ni) (st_q != ST_IDLE) |-> in_stall_o;
  endproperty
  a_no_accept_busy: assert property (p_no_accept_busy) else $error("accept while busy");

  a_clear_no_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !out_valid_o) else $error("result during clear");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(score_o)))
    else $error("stalled result lost");

endmodule
